// ----- hdl/mcat_pkg.sv -----
// shared types and constants of the multi-channel alarm timer
package mcat_pkg;

    localparam int NUM_SLOTS_DEF = 8;
    localparam logic [31:0] LATE_LIMIT_RST = 32'd60;
    localparam logic [21:0] SEC_PER_MIN = 22'd60;
    localparam int RES_CNT_W = 4;
    localparam logic [RES_CNT_W-1:0] RESULT_LIMIT = 4'd8;

    typedef enum logic [1:0] {
        ACT_TICK,
        ACT_ALLOC,
        ACT_SET_TIME,
        ACT_SET_EN
    } t_action;

    typedef enum logic [2:0] {
        ST_FIRED,
        ST_NONE,
        ST_ALLOCATED,
        ST_FULL,
        ST_WRITTEN
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_EVAL,
        S_DIV,
        S_PUSH,
        S_END,
        S_ONE
    } t_state;

    typedef struct packed {
        logic latch;
        logic clr_scan;
        logic rd;
        logic advance;
        logic tick_update;
        logic div_start;
        logic div_wb;
        logic hold_new;
        logic push_held;
        logic push_end;
        logic single_do;
    } t_cmd;

    typedef struct packed {
        t_action in_action;
        logic    no_slots;
        logic    at_last;
        logic    out_free;
        logic    fire;
        logic    late_div;
        logic    report;
        logic    held_v;
        logic    div_done;
    } t_sts;

endpackage

// ----- hdl/mcat_in_if.sv -----
// request channel carrying one input item
interface mcat_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [31:0] now_seconds;
    logic [2:0]  slot;
    logic [31:0] alarm_seconds;
    logic        enable_bit;
    logic        periodic;
    logic [15:0] interval_minutes;

    modport source (
        output valid, action, now_seconds, slot, alarm_seconds, enable_bit, periodic,
               interval_minutes,
        input  ready
    );
    modport sink (
        input  valid, action, now_seconds, slot, alarm_seconds, enable_bit, periodic,
               interval_minutes,
        output ready
    );
endinterface

// ----- hdl/mcat_out_if.sv -----
// result channel carrying one result item
interface mcat_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] status;
    logic [2:0] slot_index;
    logic       last;

    modport source (output valid, status, slot_index, last, input ready);
    modport sink (input valid, status, slot_index, last, output ready);
endinterface

// ----- hdl/mcat_cfg_if.sv -----
// configuration write channel for the late limit register
interface mcat_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

// ----- hdl/mcat_ram.sv -----
// generic single-port-write ram with registered read
module mcat_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8,
    parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ----- hdl/mcat_div.sv -----
// restoring modulo unit, one quotient bit per cycle
module mcat_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_dividend,
    input  logic [21:0] i_divisor,
    output logic        o_done,
    output logic [21:0] o_rem
);
    logic [22:0] r_rem, n_rem;
    logic [31:0] r_dvd;
    logic [21:0] r_dvs;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [22:0] w_trial;

    always_comb begin
        w_trial = {r_rem[21:0], r_dvd[31]};
        if (w_trial >= {1'b0, r_dvs}) begin
            n_rem = w_trial - {1'b0, r_dvs};
        end else begin
            n_rem = w_trial;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= 6'd32;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 6'd1;
            if (r_cnt == 6'd1) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvd <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_dvd <= {r_dvd[30:0], 1'b0};
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem[21:0];
endmodule

// ----- hdl/mcat_ctrl.sv -----
// sequencer for item handling and the tick sweep
module mcat_ctrl (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_valid,
    output logic         o_in_ready,
    input  mcat_pkg::t_sts i_sts,
    output mcat_pkg::t_cmd o_cmd
);
    import mcat_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    if (i_sts.in_action == ACT_TICK) begin
                        o_cmd.clr_scan = 1'b1;
                        n_state = i_sts.no_slots ? S_END : S_RD;
                    end else begin
                        n_state = S_ONE;
                    end
                end
            end
            S_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_EVAL;
            end
            S_EVAL: begin
                o_cmd.tick_update = 1'b1;
                if (i_sts.late_div) begin
                    o_cmd.div_start = 1'b1;
                    n_state = S_DIV;
                end else if (i_sts.fire && i_sts.report && i_sts.held_v) begin
                    n_state = S_PUSH;
                end else begin
                    // first reported firing is held until we know if it is the last
                    o_cmd.hold_new = i_sts.fire && i_sts.report;
                    o_cmd.advance  = !i_sts.at_last;
                    n_state = i_sts.at_last ? S_END : S_RD;
                end
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    o_cmd.div_wb  = 1'b1;
                    o_cmd.advance = !i_sts.at_last;
                    n_state = i_sts.at_last ? S_END : S_RD;
                end
            end
            S_PUSH: begin
                if (i_sts.out_free) begin
                    o_cmd.push_held = 1'b1;
                    o_cmd.advance   = !i_sts.at_last;
                    n_state = i_sts.at_last ? S_END : S_RD;
                end
            end
            S_END: begin
                if (i_sts.out_free) begin
                    o_cmd.push_end = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_ONE: begin
                if (i_sts.out_free) begin
                    o_cmd.single_do = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end
endmodule

// ----- hdl/mcat_dp.sv -----
// slot table, compare logic, modulo unit and result register
module mcat_dp #(
    parameter int NUM_SLOTS = mcat_pkg::NUM_SLOTS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    mcat_in_if.sink        i_in,
    mcat_out_if.source     o_out,
    mcat_cfg_if.sink       i_cfg,
    input  mcat_pkg::t_cmd i_cmd,
    output mcat_pkg::t_sts o_sts
);
    import mcat_pkg::*;

    localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CNT_W = $clog2(NUM_SLOTS + 1);

    // latched request
    t_action     r_act;
    logic [31:0] r_now;
    logic [2:0]  r_slot;
    logic [31:0] r_alarm;
    logic        r_en_bit;
    logic        r_periodic;
    logic [15:0] r_mins;

    logic [31:0] r_late_limit;

    logic [NUM_SLOTS-1:0] r_en, r_arm, r_per, r_cval;
    logic [CNT_W-1:0]     r_used;

    logic [IDX_W-1:0]     r_idx;
    logic [IDX_W-1:0]     r_held;
    logic                 r_held_v;
    logic [RES_CNT_W-1:0] r_n;

    logic        r_out_valid;
    t_status     r_status;
    logic [2:0]  r_out_slot;
    logic        r_last;

    logic [31:0] w_cmp_q, w_cmp;
    logic [21:0] w_per_q;
    logic [21:0] w_rem;
    logic        w_div_done;
    logic [31:0] w_diff;
    logic        w_active, w_due, w_late, w_fire, w_late_hit, w_per_zero;
    logic        w_full, w_in_range, w_out_free;
    logic [IDX_W-1:0] w_alloc_idx, w_slot_idx;
    logic [CNT_W-1:0] w_idx_next;
    logic        w_per_we;
    logic [21:0] w_per_wdata;
    logic        w_cmp_we;
    logic [IDX_W-1:0] w_cmp_waddr;
    logic [31:0] w_cmp_wdata;
    t_status     w_single_status;
    logic [2:0]  w_single_slot;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_late_limit <= LATE_LIMIT_RST;
        end else if (i_cfg.valid) begin
            r_late_limit <= i_cfg.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_act      <= t_action'(i_in.action);
            r_now      <= i_in.now_seconds;
            r_slot     <= i_in.slot;
            r_alarm    <= i_in.alarm_seconds;
            r_en_bit   <= i_in.enable_bit;
            r_periodic <= i_in.periodic;
            r_mins     <= i_in.interval_minutes;
        end
    end

    mcat_ram #(.WIDTH(32), .DEPTH(NUM_SLOTS), .AW(IDX_W)) u_cmp_ram (
        .i_clk   (i_clk),
        .i_we    (w_cmp_we),
        .i_waddr (w_cmp_waddr),
        .i_wdata (w_cmp_wdata),
        .i_re    (i_cmd.rd),
        .i_raddr (r_idx),
        .o_rdata (w_cmp_q)
    );

    mcat_ram #(.WIDTH(22), .DEPTH(NUM_SLOTS), .AW(IDX_W)) u_per_ram (
        .i_clk   (i_clk),
        .i_we    (w_per_we),
        .i_waddr (w_alloc_idx),
        .i_wdata (w_per_wdata),
        .i_re    (i_cmd.rd),
        .i_raddr (r_idx),
        .o_rdata (w_per_q)
    );

    mcat_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_diff),
        .i_divisor  (w_per_q),
        .o_done     (w_div_done),
        .o_rem      (w_rem)
    );

    // compare time never written reads as zero
    assign w_cmp      = r_cval[r_idx] ? w_cmp_q : 32'd0;
    assign w_diff     = r_now - w_cmp;
    assign w_active   = r_en[r_idx] && r_arm[r_idx];
    assign w_due      = r_now >= w_cmp;
    assign w_late     = w_diff > r_late_limit;
    assign w_fire     = w_active && w_due && !w_late;
    assign w_late_hit = w_active && w_due && w_late;
    assign w_per_zero = (w_per_q == 22'd0);

    assign w_full      = r_used >= CNT_W'(NUM_SLOTS);
    assign w_in_range  = 32'(r_slot) < NUM_SLOTS;
    assign w_alloc_idx = IDX_W'(r_used);
    assign w_slot_idx  = IDX_W'(r_slot);
    assign w_idx_next  = CNT_W'(r_idx) + CNT_W'(1);
    assign w_out_free  = !r_out_valid || o_out.ready;

    assign w_per_we    = i_cmd.single_do && (r_act == ACT_ALLOC) && !w_full;
    assign w_per_wdata = 22'(r_mins) * SEC_PER_MIN;

    always_comb begin
        w_cmp_we    = 1'b0;
        w_cmp_waddr = r_idx;
        w_cmp_wdata = r_now;
        if (i_cmd.single_do && (r_act == ACT_SET_TIME) && w_in_range) begin
            w_cmp_we    = 1'b1;
            w_cmp_waddr = w_slot_idx;
            w_cmp_wdata = r_alarm;
        end else if (i_cmd.tick_update && w_fire && r_per[r_idx]) begin
            w_cmp_we    = 1'b1;
            w_cmp_wdata = w_cmp + 32'(w_per_q);
        end else if (i_cmd.tick_update && w_late_hit && r_per[r_idx] && w_per_zero) begin
            w_cmp_we    = 1'b1;
            w_cmp_wdata = r_now;
        end else if (i_cmd.div_wb) begin
            // next period boundary after now
            w_cmp_we    = 1'b1;
            w_cmp_wdata = r_now + 32'(w_per_q) - 32'(w_rem);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en   <= '0;
            r_arm  <= '0;
            r_per  <= '0;
            r_cval <= '0;
            r_used <= '0;
        end else begin
            if (i_cmd.single_do) begin
                case (r_act)
                    ACT_ALLOC: begin
                        if (!w_full) begin
                            r_en[w_alloc_idx]  <= r_en_bit;
                            r_arm[w_alloc_idx] <= 1'b1;
                            r_per[w_alloc_idx] <= r_periodic;
                            r_used <= r_used + CNT_W'(1);
                        end
                    end
                    ACT_SET_EN: begin
                        if (w_in_range) begin
                            r_en[w_slot_idx] <= r_en_bit;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            if (i_cmd.tick_update && (w_fire || w_late_hit) && !r_per[r_idx]) begin
                r_arm[r_idx] <= 1'b0;
            end
            if (w_cmp_we) begin
                r_cval[w_cmp_waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx    <= '0;
            r_held   <= '0;
            r_held_v <= 1'b0;
            r_n      <= '0;
        end else if (i_cmd.clr_scan) begin
            r_idx    <= '0;
            r_held_v <= 1'b0;
            r_n      <= '0;
        end else begin
            if (i_cmd.hold_new || i_cmd.push_held) begin
                r_held   <= r_idx;
                r_held_v <= 1'b1;
                r_n      <= r_n + RES_CNT_W'(1);
            end
            if (i_cmd.advance) begin
                r_idx <= r_idx + IDX_W'(1);
            end
        end
    end

    always_comb begin
        if (r_act == ACT_ALLOC) begin
            w_single_status = w_full ? ST_FULL : ST_ALLOCATED;
            w_single_slot   = w_full ? 3'd0 : 3'(r_used);
        end else begin
            w_single_status = ST_WRITTEN;
            w_single_slot   = r_slot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.single_do || i_cmd.push_held || i_cmd.push_end) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.single_do) begin
            r_status   <= w_single_status;
            r_out_slot <= w_single_slot;
            r_last     <= 1'b1;
        end else if (i_cmd.push_held) begin
            r_status   <= ST_FIRED;
            r_out_slot <= 3'(r_held);
            r_last     <= 1'b0;
        end else if (i_cmd.push_end) begin
            r_status   <= r_held_v ? ST_FIRED : ST_NONE;
            r_out_slot <= r_held_v ? 3'(r_held) : 3'd0;
            r_last     <= 1'b1;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.status     = r_status;
    assign o_out.slot_index = r_out_slot;
    assign o_out.last       = r_last;

    assign o_sts.in_action = t_action'(i_in.action);
    assign o_sts.no_slots  = (r_used == '0);
    assign o_sts.at_last   = w_idx_next >= r_used;
    assign o_sts.out_free  = w_out_free;
    assign o_sts.fire      = w_fire;
    assign o_sts.late_div  = w_late_hit && r_per[r_idx] && !w_per_zero;
    assign o_sts.report    = r_n < RESULT_LIMIT;
    assign o_sts.held_v    = r_held_v;
    assign o_sts.div_done  = w_div_done;
endmodule

// ----- hdl/multi_channel_alarm_timer.sv -----
// top level of the multi-channel alarm timer
//
//  channel  dir  handshake      payload
//  i_in     in   valid/ready    action, now_seconds, slot, alarm_seconds, enable_bit,
//                               periodic, interval_minutes
//  o_out    out  valid/ready    status, slot_index, last
//  i_cfg    in   valid/ready    data (late limit)
//
//  allocate, set time and set enable latch in S_IDLE, then write the result from S_ONE
//  a tick runs S_RD, S_EVAL per allocated slot, S_DIV per late periodic slot of nonzero
//  period (serial modulo unit), S_PUSH per reported firing after the first, then S_END
//  one request in flight at a time; the sweep waits while the result register is full
//  synchronous reset clears flags, slot count and compare-time valid bits, no clearing pass
module multi_channel_alarm_timer #(
    parameter int NUM_SLOTS = mcat_pkg::NUM_SLOTS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mcat_in_if.sink    i_in,
    mcat_out_if.source o_out,
    mcat_cfg_if.sink   i_cfg
);
    import mcat_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;
    logic w_in_ready;

    assign i_in.ready = w_in_ready;

    mcat_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (w_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    mcat_dp #(.NUM_SLOTS(NUM_SLOTS)) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_out   (o_out),
        .i_cfg   (i_cfg),
        .i_cmd   (w_cmd),
        .o_sts   (w_sts)
    );
endmodule
